[design/audio_sample_to_pcm16_converter_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the PCM16 converter
// Short forms for clocked assertions with asynchronous reset disable.
// ----------------------------------------------------------------------------
`ifndef AUDIO_SAMPLE_TO_PCM16_CONVERTER_UNIT_MACROS_SVH
`define AUDIO_SAMPLE_TO_PCM16_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication
`define ASC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ASC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/asc_pkg.sv]
// ----------------------------------------------------------------------------
// asc_pkg
// Field widths, register indexes and reset values of the PCM16 converter.
// ----------------------------------------------------------------------------
package asc_pkg;

	localparam int SAMPLE_W = 32;
	localparam int PCM_W    = 16;

	localparam int REG_IDX_W = 2;
	localparam int REG_DATA_W = 7;

	localparam logic [REG_IDX_W-1:0] REG_SOURCE_BITS     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_IS_FLOAT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_CHANNELS = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_DEST_CHANNELS   = 2'd3;

	localparam logic [6:0] RST_SOURCE_BITS     = 7'd16;
	localparam logic       RST_SOURCE_IS_FLOAT = 1'b0;
	localparam logic [3:0] RST_SOURCE_CHANNELS = 4'd2;
	localparam logic [1:0] RST_DEST_CHANNELS   = 2'd2;

	localparam logic [6:0] BITS_8  = 7'd8;
	localparam logic [6:0] BITS_16 = 7'd16;
	localparam logic [6:0] BITS_24 = 7'd24;
	localparam logic [6:0] BITS_32 = 7'd32;

	// float exponent landmarks: 127 is 1.0, 119 puts the mantissa lsb at 2^-31
	localparam logic [7:0] EXP_ONE   = 8'd127;
	localparam logic [7:0] EXP_ALIGN = 8'd119;
	localparam logic [7:0] EXP_SPEC  = 8'hFF;

	localparam int PCM_MAX_POS = 32767;
	localparam int PCM_MAX_NEG = 32768;

	typedef logic signed [32:0] norm_t;

endpackage

[design/asc_if.sv]
// ----------------------------------------------------------------------------
// Channel interfaces of the PCM16 converter
// Valid/ready channels for source words and output PCM words.
// ----------------------------------------------------------------------------
interface asc_in_if;
	logic                          valid;
	logic                          ready;
	logic [asc_pkg::SAMPLE_W-1:0]  sample_word;

	modport source (output valid, output sample_word, input ready);
	modport sink   (input valid, input sample_word, output ready);
endinterface

interface asc_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [asc_pkg::PCM_W-1:0]  pcm_sample;
	logic                              out_channel;
	logic                              frame_last;

	modport source (output valid, output pcm_sample, output out_channel,
		output frame_last, input ready);
	modport sink   (input valid, input pcm_sample, input out_channel,
		input frame_last, output ready);
endinterface

[design/audio_sample_to_pcm16_converter_unit.sv]
// ----------------------------------------------------------------------------
// audio_sample_to_pcm16_converter_unit
// Converts interleaved 8/16/24/32-bit integer or 32-bit float sample words to
// signed 16-bit PCM, with mono downmix or stereo channel selection.
// ----------------------------------------------------------------------------
// One source word is taken at a time. A word that closes a mono frame, or a
// stereo word of channel 0 or 1, runs through a shared sequencer: normalise,
// magnitude, scale by 32767, round, then a restoring divide by the channel
// count (by one for stereo output) at one quotient bit a cycle. With
// MAX_CHANNELS = 8 the divide is 20 bits; a mono source in stereo output
// gives a second word, for channel 1, from the same result once the output
// register is free again. Words that only add to a downmix or are dropped
// go from normalise straight back to idle. The output register lets the
// next source word in while a result waits to be taken.
// ----------------------------------------------------------------------------
`include "audio_sample_to_pcm16_converter_unit_macros.svh"

module audio_sample_to_pcm16_converter_unit #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	asc_in_if.sink                          samples,
	asc_out_if.source                       pcm,
	input  logic                            wr_en,
	input  logic [asc_pkg::REG_IDX_W-1:0]   wr_index,
	input  logic [asc_pkg::REG_DATA_W-1:0]  wr_data
);

	localparam int CW    = $clog2(MAX_CHANNELS + 1);
	localparam int PW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int SUM_W = 33 + $clog2(MAX_CHANNELS);
	localparam int MAG_W = SUM_W - 1;
	localparam int PROD_W = MAG_W + 16;
	localparam int QW    = MAG_W - 15;
	localparam int KW    = $clog2(QW + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_NORM  = 3'd1;
	localparam logic [2:0] ST_ABS   = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_RND   = 3'd4;
	localparam logic [2:0] ST_DIV   = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;
	localparam logic [2:0] ST_EMIT2 = 3'd7;

	// configuration
	logic [6:0] src_bits_q;
	logic       src_float_q;
	logic [3:0] src_ch_q;
	logic [1:0] dst_ch_q;

	// sequencer and datapath
	logic [2:0]              state_q;
	logic [31:0]             word_q;
	logic [PW-1:0]           pos_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] op_q;
	logic [CW-1:0]           n_q;
	logic                    neg_q;
	logic [MAG_W-1:0]        mag_q;
	logic [PROD_W-1:0]       prod_q;
	logic [QW-1:0]           y_q;
	logic [CW-1:0]           rem_q;
	logic [KW-1:0]           cnt_q;
	logic                    och_q;
	logic                    last_q;
	logic                    dup_q;

	// output register
	logic                    ov_q;
	logic [15:0]             opcm_q;
	logic                    ooch_q;
	logic                    olast_q;

	// ------------------------------------------------------------------ norm
	logic [7:0]   f_ex;
	logic [23:0]  f_m;
	logic [7:0]   f_sd;
	logic [4:0]   f_s;
	logic [25:0]  f_rnd;
	logic [25:0]  f_tmp;
	logic [31:0]  f_mag;
	asc_pkg::norm_t v_s;

	always_comb begin
		f_ex  = word_q[30:23];
		f_m   = {1'b1, word_q[22:0]};
		f_sd  = asc_pkg::EXP_ALIGN - f_ex;
		f_s   = (f_sd > 8'd25) ? 5'd25 : f_sd[4:0];
		f_rnd = (f_s == 5'd0) ? 26'd0 : (26'd1 << (f_s - 5'd1));
		f_tmp = (26'({2'b00, f_m}) + f_rnd) >> f_s;
		if (f_ex >= asc_pkg::EXP_ONE) begin
			f_mag = 32'h8000_0000;
		end else if (f_ex == 8'd0) begin
			f_mag = '0;
		end else if (f_ex >= asc_pkg::EXP_ALIGN) begin
			f_mag = 32'(f_m) << (f_ex - asc_pkg::EXP_ALIGN);
		end else begin
			f_mag = 32'(f_tmp);
		end

		v_s = '0;
		if (src_float_q && src_bits_q == asc_pkg::BITS_32) begin
			if (f_ex == asc_pkg::EXP_SPEC && word_q[22:0] != 23'd0) begin
				v_s = '0;
			end else if (word_q[31]) begin
				v_s = -$signed({1'b0, f_mag});
			end else begin
				v_s = $signed({1'b0, f_mag});
			end
		end else begin
			case (src_bits_q)
				asc_pkg::BITS_8:  v_s = {~word_q[7], ~word_q[7], word_q[6:0], 24'd0};
				asc_pkg::BITS_16: v_s = {word_q[15], word_q[15:0], 16'd0};
				asc_pkg::BITS_24: v_s = {word_q[23], word_q[23:0], 8'd0};
				asc_pkg::BITS_32: v_s = {word_q[31], word_q};
				default:          v_s = '0;
			endcase
		end
	end

	// ------------------------------------------------------------ framing
	logic [CW-1:0]           c_eff;
	logic                    mono;
	logic                    stale;
	logic [PW-1:0]           pos_e;
	logic [4:0]              pos_n5;
	logic                    frame_end;
	logic signed [SUM_W-1:0] sum_e;
	logic signed [SUM_W-1:0] sum_n;

	always_comb begin
		if (src_ch_q == 4'd0) begin
			c_eff = CW'(1);
		end else if ({1'b0, src_ch_q} > 5'(MAX_CHANNELS)) begin
			c_eff = CW'(MAX_CHANNELS);
		end else begin
			c_eff = CW'(src_ch_q);
		end
		mono      = (dst_ch_q <= 2'd1);
		stale     = 5'(pos_q) >= 5'(c_eff);
		pos_e     = stale ? '0 : pos_q;
		sum_e     = stale ? '0 : sum_q;
		pos_n5    = 5'(pos_e) + 5'd1;
		frame_end = pos_n5 >= 5'(c_eff);
		sum_n     = sum_e + SUM_W'(v_s);
	end

	// -------------------------------------------------------- divide step
	logic [CW:0]   trial;
	logic          qbit;
	logic [16:0]   q_clamp;
	logic [15:0]   pcm_val;

	always_comb begin
		trial = {rem_q, y_q[QW-1]};
		qbit  = trial >= {1'b0, n_q};
		if (neg_q) begin
			q_clamp = (y_q > QW'(asc_pkg::PCM_MAX_NEG)) ? 17'(asc_pkg::PCM_MAX_NEG)
				: 17'(y_q);
			pcm_val = 16'(-q_clamp);
		end else begin
			q_clamp = (y_q > QW'(asc_pkg::PCM_MAX_POS)) ? 17'(asc_pkg::PCM_MAX_POS)
				: 17'(y_q);
			pcm_val = q_clamp[15:0];
		end
	end

	logic out_free;
	logic load_out;
	assign out_free      = !ov_q || pcm.ready;
	assign load_out      = out_free && (state_q == ST_EMIT || state_q == ST_EMIT2);
	assign samples.ready = (state_q == ST_IDLE);

	// ------------------------------------------------------- config regs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_bits_q  <= asc_pkg::RST_SOURCE_BITS;
			src_float_q <= asc_pkg::RST_SOURCE_IS_FLOAT;
			src_ch_q    <= asc_pkg::RST_SOURCE_CHANNELS;
			dst_ch_q    <= asc_pkg::RST_DEST_CHANNELS;
		end else if (wr_en) begin
			case (wr_index)
				asc_pkg::REG_SOURCE_BITS:     src_bits_q  <= wr_data;
				asc_pkg::REG_SOURCE_IS_FLOAT: src_float_q <= wr_data[0];
				asc_pkg::REG_SOURCE_CHANNELS: src_ch_q    <= wr_data[3:0];
				asc_pkg::REG_DEST_CHANNELS:   dst_ch_q    <= wr_data[1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			sum_q   <= '0;
			rem_q   <= '0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (load_out) begin
				ov_q <= 1'b1;
			end else if (pcm.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (samples.valid) begin
						word_q  <= samples.sample_word;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					n_q     <= CW'(1);
					op_q    <= SUM_W'(v_s);
					och_q   <= 1'b0;
					last_q  <= 1'b0;
					dup_q   <= 1'b0;
					state_q <= ST_IDLE;
					if (mono) begin
						if (frame_end) begin
							op_q    <= sum_n;
							n_q     <= c_eff;
							last_q  <= 1'b1;
							pos_q   <= '0;
							sum_q   <= '0;
							state_q <= ST_ABS;
						end else begin
							pos_q <= PW'(pos_n5);
							sum_q <= sum_n;
						end
					end else begin
						sum_q <= '0;
						if (c_eff == CW'(1)) begin
							dup_q   <= 1'b1;
							pos_q   <= '0;
							state_q <= ST_ABS;
						end else begin
							pos_q <= frame_end ? '0 : PW'(pos_n5);
							if (pos_e == PW'(0)) begin
								state_q <= ST_ABS;
							end else if (pos_e == PW'(1)) begin
								och_q   <= 1'b1;
								last_q  <= 1'b1;
								state_q <= ST_ABS;
							end
						end
					end
				end
				ST_ABS: begin
					neg_q   <= op_q[SUM_W-1];
					mag_q   <= MAG_W'(op_q[SUM_W-1] ? -op_q : op_q);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					// times 32767
					prod_q  <= (PROD_W'(mag_q) << 15) - PROD_W'(mag_q);
					state_q <= ST_RND;
				end
				ST_RND: begin
					y_q     <= QW'((prod_q + (PROD_W'(n_q) << 30)) >> 31);
					rem_q   <= '0;
					cnt_q   <= KW'(QW);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= qbit ? CW'(trial - {1'b0, n_q}) : trial[CW-1:0];
					y_q   <= {y_q[QW-2:0], qbit};
					cnt_q <= cnt_q - KW'(1);
					if (cnt_q == KW'(1)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						opcm_q  <= pcm_val;
						ooch_q  <= och_q;
						olast_q <= last_q;
						state_q <= dup_q ? ST_EMIT2 : ST_IDLE;
					end
				end
				ST_EMIT2: begin
					if (out_free) begin
						opcm_q  <= pcm_val;
						ooch_q  <= 1'b1;
						olast_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign pcm.valid       = ov_q;
	assign pcm.pcm_sample  = $signed(opcm_q);
	assign pcm.out_channel = ooch_q;
	assign pcm.frame_last  = olast_q;

	// --------------------------------------------------------- assertions
	`ASC_ASSERT_NOW(a_div_rem_below_n, state_q == ST_DIV, rem_q < n_q,
		"divider remainder not below channel count")
	`ASC_ASSERT_NOW(a_dup_first_word, state_q == ST_EMIT2 && ov_q,
		!ooch_q && !olast_q, "duplicated word pending is not channel 0")
	`ASC_ASSERT_NOW(a_right_is_last, ov_q && ooch_q, olast_q,
		"right channel word not flagged last of frame")
	`ASC_ASSERT_NEXT(a_emit_loads_output, state_q == ST_EMIT && out_free, ov_q,
		"output register not loaded on emit")

endmodule
